[src/ilha_pkg.sv]
// Shared types, constants and helpers for the implicit-list heap allocator.
// Used by ilha_alu and implicit_list_heap_allocator; no dependencies.
`default_nettype none
package ilha_pkg;

  localparam logic [31:0] HEAP_BYTES = 32'd65536;
  localparam logic [31:0] HEAP_WORDS = HEAP_BYTES / 4;
  localparam int          MEM_AW     = $clog2(HEAP_WORDS);

  localparam logic [16:0] CHUNK_RST  = 17'd256;
  localparam logic [16:0] INIT_BRK   = 17'd8;
  localparam logic [31:0] HEAD_WORD  = 32'h1;
  localparam logic [31:0] FIRST_HDR  = 32'h3;

  localparam logic [1:0]  ST_DONE    = 2'd0;
  localparam logic [1:0]  ST_EXHAUST = 2'd1;
  localparam logic [1:0]  ST_NULL    = 2'd2;

  typedef enum logic [2:0] {
    ACT_MALLOC  = 3'd0,
    ACT_FREE    = 3'd1,
    ACT_REALLOC = 3'd2,
    ACT_READ    = 3'd3,
    ACT_WRITE   = 3'd4
  } action_t;

  typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] y;
    logic        borrow;
  } alu_rsp_t;

  // block size field of a header word
  function automatic logic [31:0] hsize(input logic [31:0] h);
    return {h[31:3], 3'b000};
  endfunction

endpackage
`default_nettype wire

[src/ilha_alu.sv]
// Shared 32-bit add/subtract unit with borrow flag for the allocator sequencer.
// Depends on ilha_pkg.
`default_nettype none
module ilha_alu import ilha_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic        sub;
  logic [32:0] sum;

  assign sub = (req.op == ALU_SUB);
  assign sum = {1'b0, req.a} + {1'b0, (sub ? ~req.b : req.b)} + {32'b0, sub};

  assign rsp.y      = sum[31:0];
  assign rsp.borrow = sub & ~sum[32];   // a < b on subtract

endmodule
`default_nettype wire

[src/implicit_list_heap_allocator.sv]
// Heap allocator top level: sequencer, heap word memory and result register.
// Depends on ilha_pkg and ilha_alu.
//
// Heap allocator over a 16K x 32 word memory with boundary-tag headers and a
// first-fit walk. After reset the block sweeps the whole memory to zero, one word
// per cycle, then writes the head word, the first header and grows the heap by
// 256 bytes; in_stall stays high until that is done, while configuration
// writes are taken at any time. Every request then runs under one sequencer
// around a single add/subtract unit and a memory with one read and one write
// port, so each header touch is a read followed by a use of the read data. A
// realloc that moves the block runs a malloc, copies the payload word by word
// and then frees the old block. One request is worked at a time; the next one
// is taken as soon as the sequencer is back in idle, even while the previous
// result still waits on a stalled output.
`default_nettype none
module implicit_list_heap_allocator import ilha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [15:0] in_block_addr,
  input  wire logic [16:0] in_req_size,
  input  wire logic [31:0] in_write_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [15:0] out_result_addr,
  output      logic [31:0] out_read_data,
  output      logic [1:0]  out_status,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [16:0] cfg_data
);

  typedef enum logic [6:0] {
    S_CLR, S_I0, S_I1, S_IDLE, S_OUT, S_RD0, S_RD1, S_WR, S_MRES, S_ZR,
    ML0, FF0, FF1, FF2, FF3, MLG, MLG2, PL0, PL1, PL2, PL3, PL4, PL5, MLOK,
    G0, G1, G2, G3, G4, G5,
    MG0, MG1, MG2, MG3, MG4, MG5, MG6, MG7, MG8,
    PB0, PB1, PB2, K0, K1, D0, D1, D2, D3,
    RA0, RA0B, RA1, RA2, RA3, RS0, RS1, RS2, RS3, RS4,
    CP0, CP1, CP2, CP3, CP4, CP5
  } state_t;

  state_t state_r;
  // return points of the shared subroutines
  state_t pb_ret_r, mk_ret_r, mg_ret_r, gr_ret_r, ml_ret_r, fr_ret_r;

  logic [MEM_AW-1:0] clr_r;
  logic [16:0] chunk_r, brk_r;
  logic [15:0] addr_r;
  logic [16:0] rsz_r;
  logic [31:0] wdat_r;
  logic [15:0] res_r;
  logic [31:0] rdd_r;
  logic [1:0]  st_r;
  logic        out_valid_r;
  logic [15:0] out_res_r;
  logic [31:0] out_rdd_r;
  logic [1:0]  out_st_r;

  logic [31:0] p_r, s_r, h_r, t_r, os_r, op_r, fr_p_r;
  logic [17:0] need_r, gsz_r;
  logic        g_pb_r;
  logic [31:0] mp_r, msz_r, mn_r;
  logic        mpb_r;
  logic [31:0] pb_p_r, pb_sz_r, pb_v_r;
  logic [31:0] mk_q_r;
  logic        mk_bit_r;
  logic [16:0] off_r;
  logic [14:0] cnt_r;
  logic [1:0]  rem_r;

  // heap memory
  logic [31:0] mem [HEAP_WORDS];
  logic [31:0] rdata_r;
  logic        rok_r;
  logic [31:0] rdv;
  logic              mem_re, mem_we;
  logic [MEM_AW-1:0] mem_ra, mem_wa;
  logic [31:0]       mem_wd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic [31:0] alu_y;
  logic        byte_ok;
  logic [MEM_AW-1:0] byte_idx;
  logic        grow_fail;
  logic        in_acc;
  logic [31:0] cp_mask;
  logic [31:0] pay;
  logic [16:0] ncopy;

  ilha_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  assign alu_y    = alu_rsp.y;
  assign rdv      = rok_r ? rdata_r : '0;
  assign byte_ok  = (alu_y < HEAP_BYTES);
  assign byte_idx = alu_y[MEM_AW+1:2];

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_res_r;
  assign out_read_data   = out_rdd_r;
  assign out_status      = out_st_r;

  // heap break cannot take this growth
  assign grow_fail = (32'(brk_r) > HEAP_BYTES) ||
                     (32'(gsz_r) > (HEAP_BYTES - 32'(brk_r)));

  // old payload and copy length for a moving realloc
  assign pay   = (os_r == '0) ? '0 : alu_y;
  assign ncopy = (pay < 32'(rsz_r)) ? pay[16:0] : rsz_r;

  always_comb begin
    unique case (rem_r)
      2'd1:    cp_mask = 32'h0000_00ff;
      2'd2:    cp_mask = 32'h0000_ffff;
      2'd3:    cp_mask = 32'h00ff_ffff;
      default: cp_mask = 32'h0000_0000;
    endcase
  end

  // operand select for the shared adder
  always_comb begin
    alu_req = '{op: ALU_ADD, a: 32'd0, b: 32'd0};
    unique case (state_r)
      MG0, MG6:  alu_req = '{op: ALU_SUB, a: mp_r, b: 32'd4};
      MG1:       alu_req = '{op: ALU_ADD, a: mp_r, b: hsize(rdv)};
      MG2:       alu_req = '{op: ALU_SUB, a: mn_r, b: 32'd4};
      MG3:       alu_req = '{op: ALU_ADD, a: msz_r, b: (rdv[0] ? 32'd0 : hsize(rdv))};
      MG4:       alu_req = '{op: ALU_SUB, a: mp_r, b: 32'd8};
      MG5:       alu_req = '{op: ALU_SUB, a: mp_r, b: hsize(rdv)};
      MG7:       alu_req = '{op: ALU_ADD, a: msz_r, b: hsize(rdv)};
      PB0:       alu_req = '{op: ALU_SUB, a: pb_p_r, b: 32'd4};
      PB1:       alu_req = '{op: ALU_ADD, a: pb_p_r, b: pb_sz_r};
      PB2:       alu_req = '{op: ALU_SUB, a: t_r, b: 32'd8};
      G0:        alu_req = '{op: ALU_ADD, a: 32'(gsz_r), b: 32'd7};
      G1:        alu_req = '{op: ALU_SUB, a: 32'(brk_r), b: 32'd4};
      G3:        alu_req = '{op: ALU_ADD, a: p_r, b: 32'(gsz_r)};
      G4:        alu_req = '{op: ALU_SUB, a: t_r, b: 32'd4};
      ML0, RA0:  alu_req = '{op: ALU_ADD, a: 32'(rsz_r), b: 32'd11};
      FF0, PL0, PL3:
                 alu_req = '{op: ALU_SUB, a: p_r, b: 32'd4};
      FF2:       alu_req = '{op: ALU_SUB, a: 32'(brk_r), b: p_r};
      FF3:       alu_req = '{op: ALU_ADD, a: p_r, b: s_r};
      PL1:       alu_req = '{op: ALU_SUB, a: hsize(rdv), b: 32'(need_r) + 32'd8};
      PL2:       alu_req = '{op: ALU_ADD, a: p_r, b: s_r};
      PL4:       alu_req = '{op: ALU_ADD, a: p_r, b: 32'(need_r)};
      PL5:       alu_req = '{op: ALU_SUB, a: s_r, b: 32'(need_r)};
      K0, K1:    alu_req = '{op: ALU_SUB, a: mk_q_r, b: 32'd4};
      D0:        alu_req = '{op: ALU_SUB, a: fr_p_r, b: 32'd4};
      D2:        alu_req = '{op: ALU_ADD, a: fr_p_r, b: pb_sz_r};
      RA0B, RS0: alu_req = '{op: ALU_SUB, a: op_r, b: 32'd4};
      RA1:       alu_req = '{op: ALU_SUB, a: hsize(rdv), b: 32'(need_r)};
      RA2:       alu_req = '{op: ALU_SUB, a: os_r, b: 32'd4};
      RS1:       alu_req = '{op: ALU_ADD, a: op_r, b: 32'(need_r)};
      RS2:       alu_req = '{op: ALU_ADD, a: mp_r, b: s_r};
      CP0, CP2:  alu_req = '{op: ALU_ADD, a: op_r, b: 32'(off_r)};
      CP1, CP3, CP4:
                 alu_req = '{op: ALU_ADD, a: p_r, b: 32'(off_r)};
      default:   alu_req = '{op: ALU_ADD, a: 32'd0, b: 32'd0};
    endcase
  end

  // memory port control; heap-walk byte addresses come from the adder
  always_comb begin
    mem_re = 1'b0;
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = byte_idx;
    mem_wd = '0;
    unique case (state_r)
      MG0, MG2, MG4, MG6, G1, FF0, PL0, K0, D0, RA0B, CP0, CP2, CP3: begin
        mem_re = byte_ok;
        mem_ra = byte_idx;
      end
      S_RD0: begin
        mem_re = (32'(addr_r) < HEAP_WORDS);
        mem_ra = addr_r[MEM_AW-1:0];
      end
      PB0, PB2: begin
        mem_we = byte_ok;
        mem_wd = pb_v_r;
      end
      G4: begin
        mem_we = byte_ok;
        mem_wd = HEAD_WORD;
      end
      PL3: begin
        mem_we = byte_ok;
        mem_wd = 32'(need_r) | {30'b0, h_r[1], 1'b1};
      end
      K1: begin
        mem_we = byte_ok & rdv[0];
        mem_wd = hsize(rdv) | {30'b0, mk_bit_r, 1'b1};
      end
      RS0: begin
        mem_we = byte_ok;
        mem_wd = 32'(need_r) | {30'b0, h_r[1], h_r[0]};
      end
      CP1: begin
        mem_we = byte_ok;
        mem_wd = rdv;
      end
      CP4: begin
        mem_we = byte_ok;
        mem_wd = (rdv & ~cp_mask) | (t_r & cp_mask);
      end
      S_WR: begin
        mem_we = (32'(addr_r) < HEAP_WORDS);
        mem_wa = addr_r[MEM_AW-1:0];
        mem_wd = wdat_r;
      end
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
      end
      S_I0: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = HEAD_WORD;
      end
      S_I1: begin
        mem_we = 1'b1;
        mem_wa = MEM_AW'(1);
        mem_wd = FIRST_HDR;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
    rok_r   <= mem_re;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      chunk_r     <= CHUNK_RST;
      brk_r       <= INIT_BRK;
    end else begin
      if (cfg_valid) begin
        chunk_r <= cfg_data;
      end
      // S_OUT reloads the result register itself
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        // power-up sweep and heap init
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= S_I0;
        end
        S_I0: state_r <= S_I1;
        S_I1: begin
          brk_r    <= INIT_BRK;
          gsz_r    <= 18'(CHUNK_RST);
          gr_ret_r <= S_IDLE;
          state_r  <= G0;
        end

        S_IDLE: begin
          if (in_valid) begin
            addr_r <= in_block_addr;
            rsz_r  <= in_req_size;
            wdat_r <= in_write_data;
            res_r  <= '0;
            rdd_r  <= '0;
            st_r   <= ST_DONE;
            unique case (action_t'(in_action))
              ACT_MALLOC: begin
                ml_ret_r <= S_MRES;
                state_r  <= ML0;
              end
              ACT_FREE: begin
                if (in_block_addr[15:2] == '0) begin
                  state_r <= S_OUT;     // free of null
                end else begin
                  fr_p_r   <= {16'b0, in_block_addr[15:2], 2'b00};
                  fr_ret_r <= S_OUT;
                  state_r  <= D0;
                end
              end
              ACT_REALLOC: begin
                op_r    <= {16'b0, in_block_addr[15:2], 2'b00};
                state_r <= RA0;
              end
              ACT_READ:  state_r <= S_RD0;
              ACT_WRITE: state_r <= S_WR;
              default:   state_r <= S_OUT;
            endcase
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          rdd_r   <= rdv;
          state_r <= S_OUT;
        end
        S_WR: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_res_r   <= res_r;
            out_rdd_r   <= rdd_r;
            out_st_r    <= st_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_MRES: begin
          res_r   <= p_r[15:0];
          state_r <= S_OUT;
        end
        S_ZR: begin
          st_r    <= ST_NULL;
          state_r <= S_OUT;
        end

        // malloc: result pointer in p_r, status in st_r
        ML0: begin
          if (rsz_r == '0) begin
            st_r    <= ST_NULL;
            p_r     <= '0;
            state_r <= ml_ret_r;
          end else begin
            need_r  <= {alu_y[17:3], 3'b000};
            p_r     <= 32'd8;
            state_r <= FF0;
          end
        end
        FF0: state_r <= (p_r < 32'(brk_r)) ? FF1 : MLG;
        FF1: begin
          s_r <= hsize(rdv);
          if (hsize(rdv) == '0) begin
            state_r <= MLG;
          end else if (!rdv[0] && (32'(need_r) <= hsize(rdv))) begin
            state_r <= PL0;
          end else begin
            state_r <= FF2;
          end
        end
        FF2: state_r <= (s_r > alu_y) ? MLG : FF3;
        FF3: begin
          p_r     <= alu_y;
          state_r <= FF0;
        end
        MLG: begin
          gsz_r    <= (need_r > 18'(chunk_r)) ? need_r : 18'(chunk_r);
          gr_ret_r <= MLG2;
          state_r  <= G0;
        end
        MLG2: begin
          if (p_r == '0) begin
            st_r    <= ST_EXHAUST;
            state_r <= ml_ret_r;
          end else begin
            state_r <= PL0;
          end
        end
        PL0: state_r <= PL1;
        PL1: begin
          s_r <= hsize(rdv);
          h_r <= rdv;
          if (alu_rsp.borrow) begin
            // too small to split: take it whole
            pb_p_r   <= p_r;
            pb_sz_r  <= hsize(rdv);
            pb_v_r   <= hsize(rdv) | {30'b0, rdv[1], 1'b1};
            pb_ret_r <= PL2;
            state_r  <= PB0;
          end else begin
            state_r <= PL3;
          end
        end
        PL2: begin
          mk_q_r   <= alu_y;
          mk_bit_r <= 1'b1;
          mk_ret_r <= MLOK;
          state_r  <= K0;
        end
        PL3: state_r <= PL4;
        PL4: begin
          t_r     <= alu_y;
          state_r <= PL5;
        end
        PL5: begin
          pb_p_r   <= t_r;
          pb_sz_r  <= alu_y;
          pb_v_r   <= alu_y | 32'h2;
          pb_ret_r <= MLOK;
          state_r  <= PB0;
        end
        MLOK: begin
          st_r    <= ST_DONE;
          state_r <= ml_ret_r;
        end

        // grow: new block pointer in p_r, zero on failure
        G0: begin
          gsz_r   <= {alu_y[17:3], 3'b000};
          state_r <= G1;
        end
        G1: begin
          if (grow_fail) begin
            p_r     <= '0;
            state_r <= gr_ret_r;
          end else begin
            state_r <= G2;
          end
        end
        G2: begin
          g_pb_r   <= rdv[1];
          p_r      <= 32'(brk_r);
          pb_p_r   <= 32'(brk_r);
          pb_sz_r  <= 32'(gsz_r);
          pb_v_r   <= 32'(gsz_r) | {30'b0, rdv[1], 1'b0};
          pb_ret_r <= G3;
          state_r  <= PB0;
        end
        G3: begin
          t_r     <= alu_y;
          state_r <= G4;
        end
        G4: begin
          brk_r <= t_r[16:0];
          if (g_pb_r) begin
            state_r <= gr_ret_r;
          end else begin
            mp_r     <= p_r;
            mg_ret_r <= G5;
            state_r  <= MG0;
          end
        end
        G5: begin
          p_r     <= mp_r;
          state_r <= gr_ret_r;
        end

        // coalesce around mp_r
        MG0: state_r <= MG1;
        MG1: begin
          msz_r   <= hsize(rdv);
          mpb_r   <= rdv[1];
          mn_r    <= alu_y;
          state_r <= MG2;
        end
        MG2: state_r <= MG3;
        MG3: begin
          if (mpb_r && rdv[0]) begin
            state_r <= mg_ret_r;
          end else begin
            msz_r   <= alu_y;
            state_r <= mpb_r ? MG8 : MG4;
          end
        end
        MG4: state_r <= MG5;
        MG5: begin
          mp_r    <= alu_y;
          state_r <= MG6;
        end
        MG6: state_r <= MG7;
        MG7: begin
          msz_r   <= alu_y;
          mpb_r   <= rdv[1];
          state_r <= MG8;
        end
        MG8: begin
          pb_p_r   <= mp_r;
          pb_sz_r  <= msz_r;
          pb_v_r   <= msz_r | {30'b0, mpb_r, 1'b0};
          pb_ret_r <= mg_ret_r;
          state_r  <= PB0;
        end

        // header plus footer write
        PB0: state_r <= PB1;
        PB1: begin
          t_r     <= alu_y;
          state_r <= PB2;
        end
        PB2: state_r <= pb_ret_r;

        // write prev-allocated bit (mk_bit_r) of block at mk_q_r
        K0: state_r <= K1;
        K1: begin
          if (!rdv[0]) begin
            pb_p_r   <= mk_q_r;
            pb_sz_r  <= hsize(rdv);
            pb_v_r   <= hsize(rdv) | {30'b0, mk_bit_r, 1'b0};
            pb_ret_r <= mk_ret_r;
            state_r  <= PB0;
          end else begin
            state_r <= mk_ret_r;
          end
        end

        // free block at fr_p_r
        D0: state_r <= D1;
        D1: begin
          pb_p_r   <= fr_p_r;
          pb_sz_r  <= hsize(rdv);
          pb_v_r   <= hsize(rdv) | {30'b0, rdv[1], 1'b0};
          pb_ret_r <= D2;
          state_r  <= PB0;
        end
        D2: begin
          mk_q_r   <= alu_y;
          mk_bit_r <= 1'b0;
          mk_ret_r <= D3;
          state_r  <= K0;
        end
        D3: begin
          mp_r     <= fr_p_r;
          mg_ret_r <= fr_ret_r;
          state_r  <= MG0;
        end

        // realloc
        RA0: begin
          if (op_r == '0) begin
            ml_ret_r <= S_MRES;
            state_r  <= ML0;
          end else if (rsz_r == '0) begin
            fr_p_r   <= op_r;
            fr_ret_r <= S_ZR;
            state_r  <= D0;
          end else begin
            need_r  <= {alu_y[17:3], 3'b000};
            state_r <= RA0B;
          end
        end
        RA0B: state_r <= RA1;
        RA1: begin
          os_r <= hsize(rdv);
          h_r  <= rdv;
          if (alu_rsp.borrow) begin
            ml_ret_r <= RA2;
            state_r  <= ML0;
          end else begin
            s_r <= alu_y;
            if (alu_y < 32'd8) begin
              res_r   <= op_r[15:0];
              state_r <= S_OUT;
            end else begin
              state_r <= RS0;
            end
          end
        end
        RS0: state_r <= RS1;
        RS1: begin
          mp_r     <= alu_y;
          pb_p_r   <= alu_y;
          pb_sz_r  <= s_r;
          pb_v_r   <= s_r | 32'h2;
          pb_ret_r <= RS2;
          state_r  <= PB0;
        end
        RS2: begin
          mk_q_r   <= alu_y;
          mk_bit_r <= 1'b0;
          mk_ret_r <= RS3;
          state_r  <= K0;
        end
        RS3: begin
          mg_ret_r <= RS4;
          state_r  <= MG0;
        end
        RS4: begin
          res_r   <= op_r[15:0];
          state_r <= S_OUT;
        end
        RA2: begin
          if (p_r == '0) begin
            state_r <= S_OUT;   // status already exhausted
          end else begin
            cnt_r   <= ncopy[16:2];
            rem_r   <= ncopy[1:0];
            off_r   <= '0;
            state_r <= CP0;
          end
        end
        CP0: begin
          if (cnt_r != '0) begin
            state_r <= CP1;
          end else if (rem_r != '0) begin
            state_r <= CP2;
          end else begin
            state_r <= CP5;
          end
        end
        CP1: begin
          off_r   <= off_r + 17'd4;
          cnt_r   <= cnt_r - 1'b1;
          state_r <= CP0;
        end
        CP2: state_r <= CP3;
        CP3: begin
          t_r     <= rdv;
          state_r <= CP4;
        end
        CP4: state_r <= CP5;
        CP5: begin
          fr_p_r   <= op_r;
          fr_ret_r <= RA3;
          state_r  <= D0;
        end
        RA3: begin
          res_r   <= p_r[15:0];
          state_r <= S_OUT;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // heap break stays inside the memory and 8-byte aligned
  a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(brk_r) <= HEAP_BYTES) else $error("heap break past end of memory");
  a_brk_align: assert property (@(posedge clk) disable iff (!rst_n)
    brk_r[2:0] == 3'b000) else $error("heap break misaligned");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_we) else $error("memory write while idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE) else $error("request accepted but sequencer idle");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("result not presented");

endmodule
`default_nettype wire

[dv/tb_implicit_list_heap_allocator.sv]
// Self-checking testbench for implicit_list_heap_allocator: directed table, then
// random malloc/free/realloc/read/write traffic checked against a local heap model.
// Depends on ilha_pkg and the allocator RTL.
`default_nettype none
module tb_implicit_list_heap_allocator import ilha_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_WORDS = HEAP_WORDS;
  localparam int unsigned HEAP_TOP  = HEAP_BYTES;
  localparam int unsigned SPLIT_MIN = 8;
  localparam logic [2:0]  ACT_NOP5  = 3'd5;
  localparam logic [2:0]  ACT_NOP6  = 3'd6;
  localparam logic [2:0]  ACT_NOP7  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [15:0] in_block_addr;
  logic [16:0] in_req_size;
  logic [31:0] in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_result_addr;
  logic [31:0] out_read_data;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;

  implicit_list_heap_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_block_addr(in_block_addr), .in_req_size(in_req_size),
    .in_write_data(in_write_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_addr(out_result_addr),
    .out_read_data(out_read_data), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // one expected response per accepted request
  typedef struct {
    logic [15:0] addr;
    logic [31:0] rdata;
    logic [1:0]  st;
  } alloc_resp_t;

  // directed row; chk set means the response is typed in here
  typedef struct {
    logic [2:0]  act;
    logic [15:0] addr;
    logic [16:0] size;
    logic [31:0] data;
    bit          chk;
    logic [15:0] ea;
    logic [31:0] ed;
    logic [1:0]  es;
  } stim_row_t;

  alloc_resp_t resp_queue[$];
  int unsigned live_blocks[$];
  int          mismatch_count;
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  // ---------------------------------------------------------------------------
  // Heap model: shadow of the word memory, break and chunk register.
  // All address math is 32-bit wrapping, same as the hardware.
  // ---------------------------------------------------------------------------
  logic [31:0] heap_mem [MEM_WORDS];
  logic [31:0] heap_brk;
  logic [31:0] heap_chunk;

  function automatic logic [31:0] hm_rd(logic [31:0] a);
    logic [31:0] i;
    i = a >> 2;
    return (i < MEM_WORDS) ? heap_mem[i] : 32'd0;
  endfunction

  function automatic void hm_wr(logic [31:0] a, logic [31:0] v);
    logic [31:0] i;
    i = a >> 2;
    if (i < MEM_WORDS) heap_mem[i] = v;
  endfunction

  function automatic logic [31:0] rnd8(logic [31:0] n);
    return (n + 32'd7) & ~32'h7;
  endfunction

  function automatic logic [31:0] blk_size(logic [31:0] p);
    return hm_rd(p - 32'd4) & ~32'h7;
  endfunction

  function automatic logic [31:0] blk_used(logic [31:0] p);
    return hm_rd(p - 32'd4) & 32'h1;
  endfunction

  function automatic logic [31:0] blk_prev(logic [31:0] p);
    return (hm_rd(p - 32'd4) & 32'h2) >> 1;
  endfunction

  function automatic void set_hdr(logic [31:0] p, logic [31:0] s, logic [31:0] pb,
                                  logic [31:0] al);
    hm_wr(p - 32'd4, s | (pb << 1) | al);
  endfunction

  function automatic void set_tags(logic [31:0] p, logic [31:0] s, logic [31:0] pb,
                                   logic [31:0] al);
    logic [31:0] v;
    v = s | (pb << 1) | al;
    hm_wr(p - 32'd4, v);
    hm_wr(p + s - 32'd8, v);
  endfunction

  function automatic void tag_prev_alloc(logic [31:0] p, logic [31:0] b);
    if (blk_used(p) == 0) set_tags(p, blk_size(p), b, 32'd0);
    else set_hdr(p, blk_size(p), b, 32'd1);
  endfunction

  function automatic logic [31:0] coalesce(logic [31:0] p);
    logic [31:0] pa, na, nxt, s, pbit;
    pa   = blk_prev(p);
    nxt  = p + blk_size(p);
    na   = blk_used(nxt);
    s    = blk_size(p);
    pbit = pa;
    if (pa != 0 && na != 0) return p;
    if (na == 0) s = s + blk_size(nxt);
    if (pa == 0) begin
      p    = p - (hm_rd(p - 32'd8) & ~32'h7);
      s    = s + blk_size(p);
      pbit = blk_prev(p);
    end
    set_tags(p, s, pbit, 32'd0);
    return p;
  endfunction

  function automatic logic [31:0] raise_break(logic [31:0] s);
    logic [31:0] p, pbit;
    s = rnd8(s);
    if (heap_brk > HEAP_TOP || s > HEAP_TOP - heap_brk) return 32'd0;
    p    = heap_brk;
    pbit = blk_prev(p);
    set_tags(p, s, pbit, 32'd0);
    set_hdr(p + s, 32'd0, 32'd0, 32'd1);
    heap_brk = heap_brk + s;
    if (pbit == 0) return coalesce(p);
    return p;
  endfunction

  function automatic logic [31:0] find_first_fit(logic [31:0] need);
    logic [31:0] p, s;
    p = 32'd8;
    while (p < heap_brk) begin
      s = blk_size(p);
      if (s == 0) break;
      if (blk_used(p) == 0 && need <= s) return p;
      if (s > heap_brk - p) break;
      p = p + s;
    end
    return 32'd0;
  endfunction

  function automatic void place_block(logic [31:0] p, logic [31:0] need);
    logic [31:0] s;
    s = blk_size(p);
    if (s < need + SPLIT_MIN) begin
      set_tags(p, s, blk_prev(p), 32'd1);
      tag_prev_alloc(p + s, 32'd1);
    end else begin
      set_hdr(p, need, blk_prev(p), 32'd1);
      set_tags(p + need, s - need, 32'd1, 32'd0);
    end
  endfunction

  function automatic logic [31:0] model_malloc(logic [31:0] s, output logic [1:0] st);
    logic [31:0] need, p;
    if (s == 0) begin
      st = ST_NULL;
      return 32'd0;
    end
    need = rnd8(s + 32'd4);
    p = find_first_fit(need);
    if (p == 0) begin
      p = raise_break((need > heap_chunk) ? need : heap_chunk);
      if (p == 0) begin
        st = ST_EXHAUST;
        return 32'd0;
      end
    end
    place_block(p, need);
    st = ST_DONE;
    return p;
  endfunction

  function automatic void model_free(logic [31:0] p);
    set_tags(p, blk_size(p), blk_prev(p), 32'd0);
    tag_prev_alloc(p + blk_size(p), 32'd0);
    void'(coalesce(p));
  endfunction

  // byte-lane copy; a partial last word keeps its upper bytes
  function automatic void copy_payload(logic [31:0] dst, logic [31:0] src, logic [31:0] n);
    logic [31:0] k, r, m, a;
    r = n & 32'd3;
    for (k = 0; k < (n >> 2); k++) hm_wr(dst + 32'd4 * k, hm_rd(src + 32'd4 * k));
    if (r != 0) begin
      m = (32'd1 << (32'd8 * r)) - 32'd1;
      a = dst + 32'd4 * k;
      hm_wr(a, (hm_rd(a) & ~m) | (hm_rd(src + 32'd4 * k) & m));
    end
  endfunction

  function automatic logic [31:0] model_realloc(logic [31:0] p, logic [31:0] s,
                                                output logic [1:0] st);
    logic [31:0] need, bs, rest, np, pay, n, part;
    if (p == 0) return model_malloc(s, st);
    if (s == 0) begin
      model_free(p);
      st = ST_NULL;
      return 32'd0;
    end
    need = rnd8(s + 32'd4);
    if (need < SPLIT_MIN) need = SPLIT_MIN;
    bs = blk_size(p);
    st = ST_DONE;
    if (need > bs) begin
      np = model_malloc(s, st);
      if (np == 0) return 32'd0;
      pay = (bs >= 4) ? bs - 32'd4 : 32'd0;
      n = (pay < s) ? pay : s;
      copy_payload(np, p, n);
      model_free(p);
      return np;
    end
    rest = bs - need;
    if (rest >= SPLIT_MIN) begin
      set_hdr(p, need, blk_prev(p), blk_used(p));
      part = p + need;
      set_tags(part, rest, 32'd1, 32'd0);
      tag_prev_alloc(part + rest, 32'd0);
      void'(coalesce(part));
    end
    return p;
  endfunction

  function automatic void model_reset();
    foreach (heap_mem[i]) heap_mem[i] = 32'd0;
    heap_chunk = 32'(CHUNK_RST);
    hm_wr(32'd0, HEAD_WORD);
    hm_wr(32'd4, FIRST_HDR);
    heap_brk = 32'(INIT_BRK);
    void'(raise_break(heap_chunk));
  endfunction

  // one request through the model; also keeps the list of live blocks
  function automatic alloc_resp_t model_request(logic [2:0] act, logic [15:0] ba,
                                                logic [16:0] rs, logic [31:0] wd);
    alloc_resp_t r;
    logic [31:0] res, p;
    logic [1:0]  st;
    res = 0;
    st  = ST_DONE;
    r.rdata = 0;
    p = {16'd0, ba} & ~32'h3;
    case (act)
      ACT_MALLOC: begin
        res = model_malloc({15'd0, rs}, st);
        if (res != 0) live_blocks.push_back(res);
      end
      ACT_FREE: begin
        if (p != 0) model_free(p);
        foreach (live_blocks[i]) if (live_blocks[i] == p) begin
          live_blocks.delete(i);
          break;
        end
      end
      ACT_REALLOC: begin
        res = model_realloc(p, {15'd0, rs}, st);
        if (st != ST_EXHAUST) begin
          foreach (live_blocks[i]) if (live_blocks[i] == p) begin
            live_blocks.delete(i);
            break;
          end
          if (res != 0) live_blocks.push_back(res);
        end
      end
      ACT_READ:  r.rdata = (ba < MEM_WORDS) ? heap_mem[ba] : 32'd0;
      ACT_WRITE: if (ba < MEM_WORDS) heap_mem[ba] = wd;
      default: ;
    endcase
    r.addr = res[15:0];
    r.st   = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit, receiver stall
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("tb_implicit_list_heap_allocator: errors");
    $finish;
  end

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  // ---------------------------------------------------------------------------
  // Response checker: compares each taken response with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    alloc_resp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (resp_queue.size() == 0) begin
        error_count++;
        if (mismatch_count < 10)
          $display("unexpected response addr=%h data=%h st=%0d",
                   out_result_addr, out_read_data, out_status);
        mismatch_count++;
      end else begin
        e = resp_queue.pop_front();
        if (out_result_addr !== e.addr || out_read_data !== e.rdata || out_status !== e.st)
        begin
          error_count++;
          if (mismatch_count < 10)
            $display("mismatch: exp addr=%h data=%h st=%0d, got addr=%h data=%h st=%0d",
                     e.addr, e.rdata, e.st, out_result_addr, out_read_data, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver. Payload changes on negedge, acceptance seen at posedge.
  // Model runs at acceptance so random picks see the up-to-date heap.
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [2:0] act, logic [15:0] ba, logic [16:0] rs,
                              logic [31:0] wd, bit chk, alloc_resp_t typed);
    alloc_resp_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_block_addr <= ba;
    in_req_size   <= rs;
    in_write_data <= wd;
    do @(posedge clk); while (in_stall);
    r = model_request(act, ba, rs, wd);
    resp_queue.push_back(chk ? typed : r);
    @(negedge clk);
  endtask

  // stop sending and wait for every expected response
  task automatic drain();
    in_valid <= 1'b0;
    while (resp_queue.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_chunk(logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    heap_chunk = {15'd0, v};
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [16:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 17'($urandom_range(1, 64));
    if (r < 92) return 17'($urandom_range(65, 1024));
    if (r < 99) return 17'($urandom_range(1025, 8192));
    return ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'($urandom);
  endfunction

  // word index inside the payload of a live block
  function automatic logic [15:0] pick_payload_word(int unsigned p);
    logic [31:0] s, pw;
    s  = blk_size(p);
    pw = (s >= 8) ? (s - 32'd4) >> 2 : 32'd1;
    if (pw > 64) pw = 64;
    return 16'((p >> 2) + $urandom_range(0, pw - 1));
  endfunction

  task automatic random_request();
    int          r;
    int unsigned p;
    logic [2:0]  act;
    logic [15:0] ba;
    logic [16:0] rs;
    logic [31:0] wd;
    alloc_resp_t none;
    none = '{default: 0};
    r  = $urandom_range(0, 99);
    rs = pick_size();
    wd = $urandom;
    ba = 0;
    p  = (live_blocks.size() != 0) ?
         live_blocks[$urandom_range(0, live_blocks.size() - 1)] : 0;
    if (r < 38 && live_blocks.size() > 40) r = 50;
    if (r >= 38 && r < 96 && p == 0) r = 0;
    if (r < 38) begin
      act = ACT_MALLOC;
    end else if (r < 60) begin
      act = ACT_FREE;
      ba  = 16'(p) | 16'($urandom_range(0, 3));
    end else if (r < 72) begin
      act = ACT_REALLOC;
      ba  = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'(p);
      if ($urandom_range(0, 19) == 0) rs = 0;
    end else if (r < 84) begin
      act = ACT_WRITE;
      ba  = pick_payload_word(p);
    end else if (r < 96) begin
      act = ACT_READ;
      ba  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : pick_payload_word(p);
    end else begin
      // noise: odd codes, full-range fields, stray accesses
      case ($urandom_range(0, 5))
        0: act = ACT_MALLOC;
        1: act = ACT_READ;
        2: act = ACT_WRITE;
        3: act = ACT_NOP5;
        4: act = ACT_NOP6;
        default: act = ACT_NOP7;
      endcase
      ba = 16'($urandom);
      rs = 17'($urandom);
    end
    send_request(act, ba, rs, wd, 1'b0, none);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  stim_row_t   dir_rows [19];
  logic [16:0] phase_chunk [5];
  int          phase_idle  [5];
  int          phase_stall [5];

  initial begin
    alloc_resp_t typed;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = '0;
    in_block_addr  = '0;
    in_req_size    = '0;
    in_write_data  = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    error_count    = 0;
    model_reset();

    // reset-state rows carry their answer; the rest go through the model
    dir_rows = '{
      '{ACT_READ,    16'd0,     17'd0,      32'd0,        1, 16'd0, 32'd1, ST_DONE},
      '{ACT_READ,    16'hFFFF,  17'd0,      32'd0,        1, 16'd0, 32'd0, ST_DONE},
      '{ACT_MALLOC,  16'd0,     17'd0,      32'd0,        1, 16'd0, 32'd0, ST_NULL},
      '{ACT_FREE,    16'd0,     17'd0,      32'd0,        1, 16'd0, 32'd0, ST_DONE},
      '{ACT_NOP7,    16'hFFFF,  17'h1FFFF,  32'hFFFFFFFF, 1, 16'd0, 32'd0, ST_DONE},
      '{ACT_MALLOC,  16'd0,     17'd65536,  32'd0,        1, 16'd0, 32'd0, ST_EXHAUST},
      '{ACT_MALLOC,  16'd0,     17'd1,      32'd0,        1, 16'd8, 32'd0, ST_DONE},
      '{ACT_MALLOC,  16'd0,     17'd100,    32'd0,        0, 16'd0, 32'd0, ST_DONE},
      '{ACT_WRITE,   16'd4,     17'd0,      32'hFFFFFFFF, 0, 16'd0, 32'd0, ST_DONE},
      '{ACT_WRITE,   16'd5,     17'd0,      32'h00000000, 0, 16'd0, 32'd0, ST_DONE},
      '{ACT_WRITE,   16'hFFFF,  17'd0,      32'hFFFFFFFF, 0, 16'd0, 32'd0, ST_DONE},
      '{ACT_READ,    16'd4,     17'd0,      32'd0,        0, 16'd0, 32'd0, ST_DONE},
      '{ACT_REALLOC, 16'd16,    17'd300,    32'd0,        0, 16'd0, 32'd0, ST_DONE},
      '{ACT_REALLOC, 16'd11,    17'd1,      32'd0,        0, 16'd0, 32'd0, ST_DONE},
      '{ACT_REALLOC, 16'd0,     17'd20,     32'd0,        0, 16'd0, 32'd0, ST_DONE},
      '{ACT_MALLOC,  16'd0,     17'h1FFFF,  32'd0,        0, 16'd0, 32'd0, ST_DONE},
      '{ACT_REALLOC, 16'd16,    17'd0,      32'd0,        0, 16'd0, 32'd0, ST_DONE},
      '{ACT_FREE,    16'd9,     17'd0,      32'd0,        0, 16'd0, 32'd0, ST_DONE},
      '{ACT_READ,    16'd30,    17'd0,      32'd0,        0, 16'd0, 32'd0, ST_DONE}
    };
    // chunk, idling and stall per phase: smallest chunk, heap-sized, 1000, back to reset, random
    phase_chunk = '{17'd8, 17'd65536, 17'd1000, 17'd256, 17'd0};
    phase_idle  = '{0, 45, 0, 36, 0};
    phase_stall = '{0, 0, 45, 36, 0};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // the clearing sweep holds in_stall; config waits until it is done
    do @(posedge clk); while (in_stall);
    @(negedge clk);

    foreach (dir_rows[i]) begin
      typed.addr  = dir_rows[i].ea;
      typed.rdata = dir_rows[i].ed;
      typed.st    = dir_rows[i].es;
      send_request(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].size,
                   dir_rows[i].data, dir_rows[i].chk, typed);
    end

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_chunk((ph == 4) ? 17'($urandom_range(8, 4096)) : phase_chunk[ph]);
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int n = 0; n < 350; n++) begin
        // mid-phase pause until the pipe is empty
        if (n == 175 && ph == 1) drain();
        random_request();
      end
    end

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (resp_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (error_count == 0 && resp_queue.size() == 0) begin
      $display("tb_implicit_list_heap_allocator: clean");
    end else begin
      $display("tb_implicit_list_heap_allocator: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

[implicit_list_heap_allocator.f]
src/ilha_pkg.sv
src/ilha_alu.sv
src/implicit_list_heap_allocator.sv
dv/tb_implicit_list_heap_allocator.sv
